[src/sll_pkg.sv]
// shared types and constants for the static linked list engine
package sll_pkg;

	localparam int DEPTH_DEF  = 128;
	localparam int DATA_W_DEF = 32;
	localparam int VALUE_W    = 32;
	localparam int POS_W      = 7;
	localparam int COUNT_W    = 7;
	localparam int STATUS_W   = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_WALK,
		S_INS,
		S_DEL_LINK,
		S_DEL_FREE,
		S_RESP
	} state_t;

endpackage

[src/static_linked_list_engine.sv]
// static linked list engine: array list with free list, walked through a next-pointer ram
// an insert walks to its position, links in the head free node and answers; a delete walks, unlinks and frees,
// with one next-pointer ram read per link walked; errors skip the walk and go straight to the response state
// one item at a time: the next item can be accepted in the cycle after the result is registered
// after reset a clearing pass over every node builds the free chain, no item is accepted then
// node data is not cleared; only nodes written by an insert are ever read
module static_linked_list_engine #(
	parameter int DEPTH      = sll_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = sll_pkg::DATA_W_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [sll_pkg::POS_W-1:0]           position,
	input  logic signed [sll_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sll_pkg::STATUS_W-1:0]        status,
	output logic signed [sll_pkg::VALUE_W-1:0]  removed_value,
	output logic [sll_pkg::COUNT_W-1:0]         element_count
);

	import sll_pkg::*;

	localparam int IW   = $clog2(DEPTH);
	localparam int CMPW = ((IW > POS_W) ? IW : POS_W) + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [IW:0]   DEPTH_X  = (IW+1)'(DEPTH);

	state_t state_q, state_d;

	logic [IW-1:0]       init_q;
	logic [IW-1:0]       free_head_q;
	logic [IW-1:0]       live_count_q;
	logic                op_q;
	logic [POS_W-1:0]    steps_q;
	logic [IW-1:0]       cur_q;
	logic [IW-1:0]       succ_q;
	status_t             status_q;
	logic [VALUE_W-1:0]  removed_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [VALUE_W-1:0]  out_removed_q;
	logic [COUNT_W-1:0]  out_count_q;

	// next-pointer ram
	logic          nx_we;
	logic [IW-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
	// data ram
	logic                  dt_we;
	logic [DATA_WIDTH-1:0] dt_wdata, dt_rdata;

	logic              accept, out_free, is_full, ins_bad, del_bad, err;
	status_t           err_status;
	logic [CMPW-1:0]   pos_x, cnt_x;
	logic [IW:0]       init_nx;
	logic signed [63:0] val_x, rd_x;
	logic signed [DATA_WIDTH-1:0] dt_rdata_s;

	sll_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_next_ram (
		.clk     (clk),
		.wr_en   (nx_we),
		.wr_addr (nx_waddr),
		.wr_data (nx_wdata),
		.rd_addr (nx_raddr),
		.rd_data (nx_rdata)
	);

	sll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_data_ram (
		.clk     (clk),
		.wr_en   (dt_we),
		.wr_addr (free_head_q),
		.wr_data (dt_wdata),
		.rd_addr (nx_rdata),
		.rd_data (dt_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// admission checks against the state before the item
	assign pos_x   = CMPW'(position);
	assign cnt_x   = CMPW'(live_count_q);
	assign is_full = (live_count_q == LAST_IDX) || (free_head_q == '0);
	assign ins_bad = (pos_x == '0) || (pos_x > cnt_x + CMPW'(1));
	assign del_bad = (pos_x == '0) || (pos_x > cnt_x);

	always_comb begin
		err        = 1'b0;
		err_status = ST_DONE;
		if (operation == OP_INSERT) begin
			if (is_full) begin
				err        = 1'b1;
				err_status = ST_FULL;
			end else if (ins_bad) begin
				err        = 1'b1;
				err_status = ST_RANGE;
			end
		end else if (del_bad) begin
			err        = 1'b1;
			err_status = ST_RANGE;
		end
	end

	assign val_x      = 64'(value);
	assign dt_wdata   = val_x[DATA_WIDTH-1:0];
	assign dt_rdata_s = dt_rdata;
	assign rd_x       = 64'(dt_rdata_s);
	assign init_nx    = {1'b0, init_q} + (IW+1)'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (init_q == LAST_IDX) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) state_d = err ? S_RESP : S_WALK;
			end
			S_WALK: begin
				if (steps_q == '0) begin
					if (op_q == OP_INSERT) state_d = S_INS;
					else if (nx_rdata == '0) state_d = S_RESP;
					else state_d = S_DEL_LINK;
				end
			end
			S_INS:      state_d = S_RESP;
			S_DEL_LINK: state_d = S_DEL_FREE;
			S_DEL_FREE: state_d = S_RESP;
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default:    state_d = S_INIT;
		endcase
	end

	// memory controls
	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = cur_q;
		nx_wdata = free_head_q;
		nx_raddr = nx_rdata;
		dt_we    = 1'b0;
		unique case (state_q)
			S_INIT: begin
				nx_we    = 1'b1;
				nx_waddr = init_q;
				nx_wdata = ((init_q == '0) || (init_nx == DEPTH_X)) ? '0 : init_nx[IW-1:0];
			end
			S_IDLE: begin
				// head link is fetched every idle cycle so the walk can start at once
				nx_raddr = '0;
				dt_we    = accept && !err && (operation == OP_INSERT);
			end
			S_WALK: begin
				if (steps_q == '0 && op_q == OP_INSERT) begin
					// link predecessor to the new node, fetch the free node's successor
					nx_we    = 1'b1;
					nx_waddr = cur_q;
					nx_wdata = free_head_q;
					nx_raddr = free_head_q;
				end
			end
			S_INS: begin
				nx_we    = 1'b1;
				nx_waddr = free_head_q;
				nx_wdata = succ_q;
			end
			S_DEL_LINK: begin
				nx_we    = 1'b1;
				nx_waddr = cur_q;
				nx_wdata = nx_rdata;
			end
			S_DEL_FREE: begin
				nx_we    = 1'b1;
				nx_waddr = succ_q;
				nx_wdata = free_head_q;
			end
			S_RESP: begin
				nx_we = 1'b0;
			end
			default: begin
				nx_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			init_q       <= '0;
			free_head_q  <= IW'(1);
			live_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) init_q <= init_q + IW'(1);
			if (state_q == S_INS) begin
				free_head_q  <= nx_rdata;
				live_count_q <= live_count_q + IW'(1);
			end
			if (state_q == S_DEL_FREE) begin
				free_head_q  <= succ_q;
				live_count_q <= live_count_q - IW'(1);
			end
			if (state_q == S_RESP && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= operation;
			steps_q   <= position - POS_W'(1);
			cur_q     <= '0;
			removed_q <= '0;
			status_q  <= err_status;
		end
		if (state_q == S_WALK) begin
			if (steps_q != '0) begin
				cur_q   <= nx_rdata;
				steps_q <= steps_q - POS_W'(1);
			end else begin
				succ_q <= nx_rdata;
				if (op_q == OP_DELETE && nx_rdata == '0) status_q <= ST_RANGE;
			end
		end
		if (state_q == S_DEL_LINK) removed_q <= rd_x[VALUE_W-1:0];
		if (state_q == S_RESP && out_free) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_count_q   <= COUNT_W'(live_count_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign removed_value = out_removed_q;
	assign element_count = out_count_q;

endmodule

[src/sll_ram.sv]
// generic single-write, single-read ram with registered read data
module sll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[test/static_linked_list_engine_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the static linked list engine: list insert and delete against a queue model
module static_linked_list_engine_tb;
	import sll_pkg::*;

	localparam int LIST_CAP = DEPTH_DEF - 1;

	typedef struct {
		logic                       op;
		logic [POS_W-1:0]           pos;
		logic signed [VALUE_W-1:0]  val;
	} list_cmd_t;

	typedef struct {
		status_t                    status;
		logic signed [VALUE_W-1:0]  removed;
		logic [COUNT_W-1:0]         count;
	} list_resp_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic                        operation = OP_INSERT;
	logic [POS_W-1:0]            position = '0;
	logic signed [VALUE_W-1:0]   value = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [STATUS_W-1:0]         status;
	logic signed [VALUE_W-1:0]   removed_value;
	logic [COUNT_W-1:0]          element_count;

	// list contents in order, element 1 at index 0
	logic signed [VALUE_W-1:0]   list_contents[$];
	list_resp_t                  expected_results[$];
	list_cmd_t                   cmd_queue[$];

	int failures = 0;
	int send_idle_pct = 19;
	int recv_idle_pct = 59;
	// accepted items counted by the monitor, and the count the driver has seen
	int accept_seq = 0;
	int seen_seq = 0;
	// element count as the generator sees it, so positions can be kept mostly legal
	int gen_count = 0;
	bit gen_grow = 1'b1;

	static_linked_list_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.position      (position),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.removed_value (removed_value),
		.element_count (element_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic list_resp_t list_apply(list_cmd_t c);
		list_resp_t r;
		r.status = ST_DONE;
		r.removed = '0;
		if (c.op == OP_INSERT) begin
			// full check wins over the position check
			if (list_contents.size() >= LIST_CAP)
				r.status = ST_FULL;
			else if (c.pos == 0 || c.pos > list_contents.size() + 1)
				r.status = ST_RANGE;
			else
				list_contents.insert(c.pos - 1, c.val);
		end else begin
			if (c.pos == 0 || c.pos > list_contents.size())
				r.status = ST_RANGE;
			else begin
				r.removed = list_contents[c.pos - 1];
				list_contents.delete(c.pos - 1);
			end
		end
		r.count = COUNT_W'(list_contents.size());
		return r;
	endfunction

	task automatic push_cmd(logic op, logic [POS_W-1:0] pos, logic signed [VALUE_W-1:0] val);
		list_cmd_t c;
		c.op = op;
		c.pos = pos;
		c.val = val;
		cmd_queue.push_back(c);
		if (op == OP_INSERT) begin
			if (gen_count < LIST_CAP && pos != 0 && pos <= gen_count + 1)
				gen_count++;
		end else if (pos != 0 && pos <= gen_count)
			gen_count--;
	endtask

	task automatic push_random();
		logic op;
		int pos;
		logic signed [VALUE_W-1:0] val;
		if (gen_count == 0)
			gen_grow = 1'b1;
		// linger a little at full so inserts hit the full case
		if (gen_count == LIST_CAP && $urandom_range(99) < 30)
			gen_grow = 1'b0;
		if ($urandom_range(99) < 2)
			gen_grow = !gen_grow;
		if ($urandom_range(99) < 85)
			op = gen_grow ? OP_INSERT : OP_DELETE;
		else
			op = gen_grow ? OP_DELETE : OP_INSERT;
		if ($urandom_range(99) < 8)
			pos = $urandom_range(127);
		else if (op == OP_INSERT)
			pos = $urandom_range((gen_count < LIST_CAP) ? gen_count + 1 : LIST_CAP, 1);
		else
			pos = (gen_count == 0) ? 1 : $urandom_range(gen_count, 1);
		case ($urandom_range(9))
			0: val = 32'h8000_0000;
			1: val = 32'h7fff_ffff;
			default: val = $urandom();
		endcase
		push_cmd(op, pos[POS_W-1:0], val);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	always @(negedge clk) begin : driver
		list_cmd_t c;
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (!in_valid || accept_seq != seen_seq) begin
			seen_seq = accept_seq;
			if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				c = cmd_queue.pop_front();
				in_valid <= 1'b1;
				operation <= c.op;
				position <= c.pos;
				value <= c.val;
			end else
				in_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin : monitor
		list_cmd_t c;
		list_resp_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				c.op = operation;
				c.pos = position;
				c.val = value;
				expected_results.push_back(list_apply(c));
				accept_seq++;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d removed_value %h element_count %0d",
						status, removed_value, element_count);
					failures++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						failures++;
					end
					if (removed_value !== want.removed) begin
						$error("removed_value: expected %h, got %h", want.removed, removed_value);
						failures++;
					end
					if (element_count !== want.count) begin
						$error("element_count: expected %0d, got %0d", want.count, element_count);
						failures++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		int phase;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list, bad positions
		push_cmd(OP_DELETE, 7'd1, 32'sd0);
		push_cmd(OP_INSERT, 7'd0, 32'sd5);
		push_cmd(OP_INSERT, 7'd2, 32'sd5);
		// build at head, tail and middle with extreme values, then try out-of-range positions
		push_cmd(OP_INSERT, 7'd1, 32'h7fff_ffff);
		push_cmd(OP_INSERT, 7'd1, 32'h8000_0000);
		push_cmd(OP_INSERT, 7'd3, 32'hffff_ffff);
		push_cmd(OP_INSERT, 7'd2, 32'h0000_0000);
		push_cmd(OP_INSERT, 7'd127, 32'sd1);
		push_cmd(OP_INSERT, 7'd6, 32'sd1);
		push_cmd(OP_DELETE, 7'd0, 32'sd0);
		push_cmd(OP_DELETE, 7'd5, 32'sd0);
		// unlink tail, head, then reuse freed nodes
		push_cmd(OP_DELETE, 7'd4, 32'sd0);
		push_cmd(OP_DELETE, 7'd1, 32'sd0);
		push_cmd(OP_INSERT, 7'd3, 32'h5555_5555);
		push_cmd(OP_DELETE, 7'd2, 32'sd0);
		push_cmd(OP_DELETE, 7'd1, 32'sd0);
		push_cmd(OP_DELETE, 7'd1, 32'sd0);
		push_cmd(OP_DELETE, 7'd1, 32'sd0);
		push_cmd(OP_INSERT, 7'd1, 32'haaaa_aaaa);
		// value is don't-care on delete
		push_cmd(OP_DELETE, 7'd1, 32'hdead_beef);
		wait_drained();

		for (phase = 0; phase < 3; phase++) begin
			if (phase == 0) begin
				send_idle_pct = 19;
				recv_idle_pct = 59;
			end else if (phase == 1) begin
				send_idle_pct = 59;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (250) push_random();
			wait_drained();
		end

		// leave time for the longest walk before checking for missing results
		repeat (200) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			failures++;
		end
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
src/sll_pkg.sv
src/sll_ram.sv
src/static_linked_list_engine.sv
test/static_linked_list_engine_tb.sv
